// ===== sv/gsad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsad_pkg: shared types and constants for the Golay (23,12) decoder
// Widths, pair enumeration helpers and register indexes used by all modules.
// ----------------------------------------------------------------------------
package gsad_pkg;

  localparam int CODE_LEN  = 23;
  localparam int SYN_W     = 11;
  localparam int MAT_BITS  = CODE_LEN * SYN_W;          // 253
  localparam int NPAIR     = CODE_LEN * (CODE_LEN - 1) / 2;
  localparam int STEP_W    = 5;
  // step 0 checks singles and pairs, steps 1..21 check triples led by a = step-1
  localparam int LAST_STEP = CODE_LEN - 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int PART3_W   = MAT_BITS - 3 * CFG_W;      // 61

  typedef logic [CODE_LEN-1:0]             word_t;
  typedef logic [SYN_W-1:0]                syn_t;
  typedef logic [CODE_LEN:0]               dec_t;
  typedef logic [STEP_W-1:0]               step_t;
  typedef logic [CODE_LEN-1:0][SYN_W-1:0]  col_arr_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PART0 = 3'd0,
    REG_PART1 = 3'd1,
    REG_PART2 = 3'd2,
    REG_PART3 = 3'd3
  } cfg_reg_t;

  // one queued request: word and its syndrome
  typedef struct packed {
    word_t word;
    syn_t  syn;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // lower position of pair p in lexicographic order
  function automatic int pair_lo(input int p);
    int k;
    int res;
    k = 0;
    res = 0;
    for (int a = 0; a < CODE_LEN; a++) begin
      for (int b = a + 1; b < CODE_LEN; b++) begin
        if (k == p) res = a;
        k++;
      end
    end
    return res;
  endfunction

  // upper position of pair p in lexicographic order
  function automatic int pair_hi(input int p);
    int k;
    int res;
    k = 0;
    res = 0;
    for (int a = 0; a < CODE_LEN; a++) begin
      for (int b = a + 1; b < CODE_LEN; b++) begin
        if (k == p) res = b;
        k++;
      end
    end
    return res;
  endfunction

  // two-bit error mask of pair p
  function automatic word_t pair_mask(input int p);
    word_t m;
    m = '0;
    m[pair_lo(p)] = 1'b1;
    m[pair_hi(p)] = 1'b1;
    return m;
  endfunction

endpackage

// ===== sv/gsad_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsad_front: request intake and syndrome computation
// Accepts a received word, XORs the check columns of its set bits and
// pushes word plus syndrome into the request queue.
// ----------------------------------------------------------------------------
module gsad_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  gsad_pkg::word_t     in_received_word,
  input  gsad_pkg::col_arr_t  cols,
  input  gsad_pkg::q_status_t q_status,
  output logic                q_push,
  output gsad_pkg::q_entry_t  q_entry
);

  gsad_pkg::syn_t syn;

  // syndrome: XOR of columns at set positions
  always_comb begin
    syn = '0;
    for (int n = 0; n < gsad_pkg::CODE_LEN; n++) begin
      if (in_received_word[n]) syn = syn ^ cols[n];
    end
  end

  assign in_ready      = !q_status.full;
  assign q_push        = in_valid && !q_status.full;
  assign q_entry.word  = in_received_word;
  assign q_entry.syn   = syn;

endmodule

// ===== sv/gsad_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsad_queue: small request queue between front and back
// Show-ahead FIFO of word/syndrome entries; DEPTH >= 2.
// ----------------------------------------------------------------------------
module gsad_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gsad_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output gsad_pkg::q_entry_t  head_entry,
  output gsad_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gsad_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_entry   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

// ===== sv/gsad_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsad_back: error pattern search and result register
// Step 0 compares all singles and pairs against the syndrome; each later
// step fixes the lowest triple position and compares all pairs above it.
// ----------------------------------------------------------------------------
module gsad_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gsad_pkg::col_arr_t  cols,
  input  gsad_pkg::q_status_t q_status,
  input  gsad_pkg::q_entry_t  q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output gsad_pkg::dec_t      out_decoded_word
);

  localparam int NPAIR = gsad_pkg::NPAIR;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  gsad_pkg::word_t       word_r, word_nxt;
  gsad_pkg::syn_t        syn_r, syn_nxt;
  gsad_pkg::step_t       step_r, step_nxt;
  gsad_pkg::word_t       pat_r, pat_nxt;
  logic                  out_valid_r, out_valid_nxt;
  gsad_pkg::dec_t        out_data_r, out_data_nxt;

  gsad_pkg::step_t       lead;
  gsad_pkg::syn_t        target;
  gsad_pkg::word_t       single_hit, single_first;
  logic [NPAIR-1:0]      pair_hit, pair_first;
  gsad_pkg::word_t       pair_pat, found_pat, fixed;
  logic                  found;

  // lead position of the triple and the syndrome left for the pair
  assign lead   = step_r - 1'b1;
  assign target = (step_r == '0) ? syn_r : (syn_r ^ cols[lead]);

  // single compares
  always_comb begin
    for (int n = 0; n < gsad_pkg::CODE_LEN; n++) begin
      single_hit[n] = (cols[n] == syn_r);
    end
  end

  // pair compares, only pairs wholly above the lead position count
  for (genvar p = 0; p < NPAIR; p++) begin : g_pair
    localparam int LO = gsad_pkg::pair_lo(p);
    localparam int HI = gsad_pkg::pair_hi(p);
    assign pair_hit[p] = ((cols[LO] ^ cols[HI]) == target) &&
                         (gsad_pkg::step_t'(LO) >= step_r);
  end

  // lowest set bit picks the first hit in search order
  assign single_first = single_hit & (~single_hit + 1'b1);
  assign pair_first   = pair_hit & (~pair_hit + 1'b1);

  always_comb begin
    pair_pat = '0;
    for (int p = 0; p < NPAIR; p++) begin
      if (pair_first[p]) pair_pat = pair_pat | gsad_pkg::pair_mask(p);
    end
  end

  // pattern chosen at this step
  always_comb begin
    if (step_r == '0) begin
      found     = (|single_hit) || (|pair_hit);
      found_pat = (|single_hit) ? single_first : pair_pat;
    end else begin
      found     = |pair_hit;
      found_pat = pair_pat | (gsad_pkg::word_t'(1) << lead);
    end
  end

  assign fixed = word_r ^ pat_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    syn_nxt       = syn_r;
    step_nxt      = step_r;
    pat_nxt       = pat_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          word_nxt  = q_entry.word;
          syn_nxt   = q_entry.syn;
          step_nxt  = '0;
          pat_nxt   = '0;
          // zero syndrome: no correction
          state_nxt = (q_entry.syn == '0) ? ST_DONE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (found || step_r == gsad_pkg::step_t'(gsad_pkg::LAST_STEP)) begin
          pat_nxt   = found ? found_pat : '0;
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = {^fixed, fixed};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    syn_r      <= syn_nxt;
    step_r     <= step_nxt;
    pat_r      <= pat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_decoded_word = out_data_r;

endmodule

// ===== sv/golay_standard_array_decoder.sv =====
`timescale 1ns / 1ps
// Flow: a zero-syndrome word passes from the queue through the idle and done states
//   to the result register; other words also pass through up to 22 search steps.
// Throughput: one word at a time in the back end; the search sequencer stepping one
//   triple lead position per cycle sets it, the request queue hides front stalls.
// Reset: synchronous active-low rst_n empties the queue, idles the search and
//   clears the parity-check matrix registers to zero.
// ----------------------------------------------------------------------------
// golay_standard_array_decoder: Golay (23,12) syndrome decoder, top level
// Holds the loadable parity-check matrix and joins front, queue and back.
// ----------------------------------------------------------------------------
module golay_standard_array_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gsad_pkg::CODE_LEN-1:0]     in_received_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gsad_pkg::CODE_LEN:0]       out_decoded_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gsad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gsad_pkg::CFG_W-1:0]        cfg_data
);

  logic [gsad_pkg::CFG_W-1:0]     part0_r, part1_r, part2_r;
  logic [gsad_pkg::PART3_W-1:0]   part3_r;
  logic [gsad_pkg::MAT_BITS-1:0]  mat;
  gsad_pkg::col_arr_t             cols;
  gsad_pkg::q_status_t            q_status;
  gsad_pkg::q_entry_t             push_entry, head_entry;
  logic                           q_push, q_pop;

  // configuration writes, unknown indexes ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part0_r <= '0;
      part1_r <= '0;
      part2_r <= '0;
      part3_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gsad_pkg::REG_PART0: part0_r <= cfg_data;
        gsad_pkg::REG_PART1: part1_r <= cfg_data;
        gsad_pkg::REG_PART2: part2_r <= cfg_data;
        gsad_pkg::REG_PART3: part3_r <= cfg_data[gsad_pkg::PART3_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack columns: row i of column n at bit n*11+i
  assign mat = {part3_r, part2_r, part1_r, part0_r};
  for (genvar n = 0; n < gsad_pkg::CODE_LEN; n++) begin : g_col
    assign cols[n] = mat[n*gsad_pkg::SYN_W +: gsad_pkg::SYN_W];
  end

  gsad_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_received_word (in_received_word),
    .cols             (cols),
    .q_status         (q_status),
    .q_push           (q_push),
    .q_entry          (push_entry)
  );

  gsad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head_entry (head_entry),
    .status     (q_status)
  );

  gsad_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cols             (cols),
    .q_status         (q_status),
    .q_entry          (head_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_decoded_word (out_decoded_word)
  );

endmodule

// ===== sv/gsad_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsad_checker: port-level checks for the Golay decoder
// Watches the top-level ports; attached by bind below.
// ----------------------------------------------------------------------------
module gsad_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gsad_pkg::CODE_LEN:0]   out_decoded_word,
  input logic                          cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_decoded_word))
    else $error("result changed while stalled");

  // appended bit makes the 24-bit result even parity
  a_out_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (^out_decoded_word) == 1'b0)
    else $error("result parity bit wrong");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // configuration writes never stall
  a_cfg_ready: assert property (@(posedge clk)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind golay_standard_array_decoder gsad_checker u_gsad_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_decoded_word (out_decoded_word),
  .cfg_ready        (cfg_ready)
);
